>>> sv/tsiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsiq_pkg - shared types and constants of the sorted insertion queue
// Beat formats, stored entry format, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package tsiq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 16;
    localparam int ENTRY_W      = 2 * KEY_W;
    localparam int OUT_COUNT_W  = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic signed [KEY_W-1:0] in_priority;
        logic signed [KEY_W-1:0] in_cost;
    } t_in;

    typedef struct packed {
        logic signed [KEY_W-1:0]   out_priority;
        logic signed [KEY_W-1:0]   out_cost;
        logic                      entry_valid;
        logic [OUT_COUNT_W-1:0]    entry_count;
        logic                      dropped;
        logic                      last;
    } t_out;

    typedef struct packed {
        logic signed [KEY_W-1:0] pri;
        logic signed [KEY_W-1:0] cost;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_HEAD,
        ST_DUMP,
        ST_DRAIN
    } t_state;

endpackage

>>> sv/two_key_sorted_insert_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_key_sorted_insert_queue - sorted insertion queue on a priority and a cost
// Keeps entries in ascending (priority, cost) order in one RAM, walked by a
// small sequencer around a single shared key comparator.
// ----------------------------------------------------------------------------
// A beat is taken at a rising edge with start high and busy low. An insert
// into an empty or a full store, and a dump of an empty store, complete
// without raising busy. Any other insert walks the store from its tail
// towards its head, one entry per cycle, moving each entry that does not sort
// ahead of the new key up by one slot; busy stays high until every entry at
// or after the insertion point has moved up and the new key is written. The
// walk is set by the single RAM read port and the one comparator. A dump
// keeps busy high until it has read every entry out of the RAM; its results
// pass the RAM read register and the result register and then come one per
// cycle, each on o_result for exactly one cycle under o_strobe. The receiver
// cannot stall the block: every result must be taken in the cycle it is
// shown. A dump leaves the store unchanged. An insert into a full store is
// dropped and sets the sticky dropped flag, which only reset clears.
// ----------------------------------------------------------------------------
module two_key_sorted_insert_queue #(
    parameter int CAPACITY = tsiq_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tsiq_pkg::t_in  i_item,
    output logic           o_strobe,
    output tsiq_pkg::t_out o_result
);
    import tsiq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer and status
    t_state         r_state, n_state;
    logic [AW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_count, n_count;
    logic           r_dropped, n_dropped;
    // read pipeline tracking for the dump
    logic           r_rd_pend, n_rd_pend;
    logic           r_rd_last, n_rd_last;
    // result register
    logic           r_strobe, n_strobe;
    t_out           r_result, n_result;
    // key of the insert in flight
    t_entry         r_key, n_key;

    // RAM and comparator hookup
    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    t_entry         ram_wr_data;
    logic [AW-1:0]  ram_rd_addr;
    t_entry         ram_rd_data;
    logic           precedes;

    logic           accept;
    logic           is_full;
    logic           is_empty;
    logic           dump_last;
    t_entry         in_key;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start & ~busy;
    assign is_full   = (r_count == CW'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign dump_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign in_key.pri  = i_item.in_priority;
    assign in_key.cost = i_item.in_cost;

    tsiq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    tsiq_cmp u_cmp (
        .i_stored   (ram_rd_data),
        .i_key      (r_key),
        .o_precedes (precedes)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == OP_DUMP) begin
                        if (!is_empty) begin
                            n_state = ST_DUMP;
                        end
                    end else if (!is_full && !is_empty) begin
                        n_state = ST_INS_CMP;
                    end
                end
            end
            ST_INS_CMP: begin
                if (precedes) begin
                    n_state = ST_IDLE;
                end else if (r_idx == '0) begin
                    n_state = ST_INS_HEAD;
                end
            end
            ST_INS_HEAD: begin
                n_state = ST_IDLE;
            end
            ST_DUMP: begin
                if (dump_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx       = r_idx;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_key       = r_key;
        n_rd_pend   = 1'b0;
        n_rd_last   = 1'b0;
        n_strobe    = 1'b0;
        n_result    = r_result;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx + AW'(1);
        ram_wr_data = r_key;
        ram_rd_addr = r_idx;

        // a read issued last cycle is on the RAM output now: emit it
        if (r_rd_pend) begin
            n_strobe              = 1'b1;
            n_result.out_priority = ram_rd_data.pri;
            n_result.out_cost     = ram_rd_data.cost;
            n_result.entry_valid  = 1'b1;
            n_result.entry_count  = OUT_COUNT_W'(r_count);
            n_result.dropped      = r_dropped;
            n_result.last         = r_rd_last;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == OP_DUMP) begin
                        if (is_empty) begin
                            // empty store: one invalid, final beat
                            n_strobe              = 1'b1;
                            n_result.out_priority = '0;
                            n_result.out_cost     = '0;
                            n_result.entry_valid  = 1'b0;
                            n_result.entry_count  = OUT_COUNT_W'(r_count);
                            n_result.dropped      = r_dropped;
                            n_result.last         = 1'b1;
                        end else begin
                            n_idx = '0;
                        end
                    end else if (is_full) begin
                        // drop the entry, remember it
                        n_dropped = 1'b1;
                    end else if (is_empty) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = in_key;
                        n_count     = r_count + CW'(1);
                    end else begin
                        // start the walk at the tail entry
                        n_key       = in_key;
                        n_idx       = AW'(r_count - CW'(1));
                        ram_rd_addr = AW'(r_count - CW'(1));
                    end
                end
            end
            ST_INS_CMP: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx + AW'(1);
                if (precedes) begin
                    // slot above this entry takes the new key
                    ram_wr_data = r_key;
                    n_count     = r_count + CW'(1);
                end else begin
                    // shift this entry up and look one lower
                    ram_wr_data = ram_rd_data;
                    if (r_idx != '0) begin
                        n_idx       = r_idx - AW'(1);
                        ram_rd_addr = r_idx - AW'(1);
                    end
                end
            end
            ST_INS_HEAD: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = r_key;
                n_count     = r_count + CW'(1);
            end
            ST_DUMP: begin
                ram_rd_addr = r_idx;
                n_rd_pend   = 1'b1;
                n_rd_last   = dump_last;
                if (!dump_last) begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_DRAIN: begin
                // hold until the final read has been emitted
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_last <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_rd_pend <= n_rd_pend;
            r_rd_last <= n_rd_last;
            r_strobe  <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> sv/tsiq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsiq_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsiq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/tsiq_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsiq_cmp - two-key ordering compare
// Flags a stored entry that sorts strictly ahead of the new key.
// ----------------------------------------------------------------------------
module tsiq_cmp (
    input  tsiq_pkg::t_entry i_stored,
    input  tsiq_pkg::t_entry i_key,
    output logic             o_precedes
);
    import tsiq_pkg::*;

    logic pri_lt;
    logic pri_eq;
    logic cost_lt;

    assign pri_lt     = i_stored.pri < i_key.pri;
    assign pri_eq     = i_stored.pri == i_key.pri;
    assign cost_lt    = i_stored.cost < i_key.cost;
    // equal keys do not precede, so a new entry lands in front of its twins
    assign o_precedes = pri_lt | (pri_eq & cost_lt);

endmodule

>>> verif/tsiq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsiq_order_checker - result checker for the sorted insertion queue
// Watches the command and result channels, keeps its own sorted copy of the
// store, queues the beats that each dump should produce and compares every
// result beat with the oldest queued one.
// ----------------------------------------------------------------------------
module tsiq_order_checker #(
    parameter int CAPACITY = tsiq_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  tsiq_pkg::t_in  i_item,
    input  logic           i_strobe,
    input  tsiq_pkg::t_out i_result,
    output int             o_pending,
    output int             o_mismatches
);
    import tsiq_pkg::*;

    t_entry held_entries [CAPACITY];
    int     held_count;
    logic   held_dropped;
    t_out   due_results [$];
    int     mismatches   = 0;
    int     results_seen = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        mismatches++;
    endtask

    function automatic bit sorts_ahead(input t_entry e, input t_in beat);
        return (e.pri < beat.in_priority) ||
               (e.pri == beat.in_priority && e.cost < beat.in_cost);
    endfunction

    // Place the new key in front of any equal key; refuse it when full.
    function automatic void take_insert(input t_in beat);
        int slot;
        int k;
        if (held_count >= CAPACITY) begin
            held_dropped = 1'b1;
            return;
        end
        slot = 0;
        while (slot < held_count && sorts_ahead(held_entries[slot], beat)) begin
            slot++;
        end
        for (k = held_count; k > slot; k--) begin
            held_entries[k] = held_entries[k-1];
        end
        held_entries[slot].pri  = beat.in_priority;
        held_entries[slot].cost = beat.in_cost;
        held_count++;
    endfunction

    // Queue one beat per stored entry, or a single invalid beat when empty.
    function automatic void queue_dump();
        t_out r;
        int   k;
        if (held_count == 0) begin
            r         = '0;
            r.dropped = held_dropped;
            r.last    = 1'b1;
            due_results.push_back(r);
            return;
        end
        for (k = 0; k < held_count; k++) begin
            r.out_priority = held_entries[k].pri;
            r.out_cost     = held_entries[k].cost;
            r.entry_valid  = 1'b1;
            r.entry_count  = OUT_COUNT_W'(held_count);
            r.dropped      = held_dropped;
            r.last         = (k == held_count - 1);
            due_results.push_back(r);
        end
    endfunction

    task automatic compare_result(input t_out want, input t_out got);
        if (got.out_priority !== want.out_priority)
            report_mismatch($sformatf("result %0d out_priority: expected %0d, got %0d",
                            results_seen, want.out_priority, got.out_priority));
        if (got.out_cost !== want.out_cost)
            report_mismatch($sformatf("result %0d out_cost: expected %0d, got %0d",
                            results_seen, want.out_cost, got.out_cost));
        if (got.entry_valid !== want.entry_valid)
            report_mismatch($sformatf("result %0d entry_valid: expected %0b, got %0b",
                            results_seen, want.entry_valid, got.entry_valid));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("result %0d entry_count: expected %0d, got %0d",
                            results_seen, want.entry_count, got.entry_count));
        if (got.dropped !== want.dropped)
            report_mismatch($sformatf("result %0d dropped: expected %0b, got %0b",
                            results_seen, want.dropped, got.dropped));
        if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last: expected %0b, got %0b",
                            results_seen, want.last, got.last));
    endtask

    // Sample on the rising edge only: stimulus and block outputs both move
    // by nonblocking update, so the pre-edge values are seen here.
    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            held_count   = 0;
            held_dropped = 1'b0;
            due_results.delete();
        end else begin
            if (i_strobe === 1'b1) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing outstanding: %h",
                                    i_result));
                end else begin
                    want = due_results.pop_front();
                    compare_result(want, i_result);
                end
                results_seen++;
            end
            if (i_start && i_busy === 1'b0) begin
                if (i_item.opcode == OP_DUMP) begin
                    queue_dump();
                end else begin
                    take_insert(i_item);
                end
            end
        end
        o_pending <= due_results.size();
    end

endmodule

>>> verif/tb_two_key_sorted_insert_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_key_sorted_insert_queue - testbench of the sorted insertion queue
// Drives insert and dump commands in random bursts, with a directed opening
// on extreme and tied keys, and leaves all checking to the order checker.
// ----------------------------------------------------------------------------
module tb_two_key_sorted_insert_queue;
    import tsiq_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int ITEMS      = 370;
    // Idle cycles in a row with no beat taken and no result shown; the
    // longest legal stretch is a full insert walk plus a sender gap.
    localparam int IDLE_LIMIT = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  item    = '0;
    logic busy;
    logic strobe;
    t_out result;
    int   pending;
    int   mismatches;
    int   beats_sent;
    int   idle_cycles;

    always #10 i_clk = ~i_clk;

    two_key_sorted_insert_queue #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item),
        .o_strobe (strobe),
        .o_result (result)
    );

    tsiq_order_checker #(
        .CAPACITY (CAPACITY)
    ) order_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Mix full-range keys with a narrow band (for ties), the corners and a
    // cluster around zero.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = int'($urandom_range(0, 6)) - 3;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(0, 200)) - 100;
        endcase
        return v[KEY_W-1:0];
    endfunction

    function automatic t_in insert_beat(input logic signed [KEY_W-1:0] p,
                                        input logic signed [KEY_W-1:0] c);
        return '{opcode: OP_INSERT, in_priority: p, in_cost: c};
    endfunction

    // Key fields of a dump carry noise; the block must ignore them.
    function automatic t_in dump_beat();
        return '{opcode: OP_DUMP, in_priority: KEY_W'($urandom()),
                 in_cost: KEY_W'($urandom())};
    endfunction

    // Present a beat from the current edge and hold it until it is taken.
    // Return on the accepting edge with start still high.
    task automatic send_beat(input t_in beat);
        start <= 1'b1;
        item  <= beat;
        do @(posedge i_clk); while (busy !== 1'b0);
        beats_sent++;
    endtask

    // Drop start, scramble the idle payload and wait out the gap.
    task automatic idle_for(input int cycles);
        start <= 1'b0;
        item  <= t_in'($urandom());
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every queued result has come back. The checker's count
    // is registered, so advance once before reading it.
    task automatic hold_until_drained();
        idle_for(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int burst;
        int k;
        beats_sent = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: empty dump, a single entry, the key extremes,
        // an exact duplicate (must land in front), and cost-only ordering.
        send_beat(dump_beat());
        send_beat(insert_beat(16'sd0, 16'sd0));
        send_beat(dump_beat());
        send_beat(insert_beat(16'sh7fff, 16'sh7fff));
        send_beat(insert_beat(-16'sh8000, -16'sh8000));
        send_beat(insert_beat(16'sd0, 16'sd0));
        send_beat(insert_beat(16'sd0, -16'sd1));
        send_beat(insert_beat(16'sd0, 16'sd1));
        send_beat(insert_beat(-16'sd1, 16'sh7fff));
        send_beat(insert_beat(16'sd1, -16'sh8000));
        send_beat(dump_beat());
        hold_until_drained();
        send_beat(insert_beat(-16'sh8000, 16'sh7fff));
        send_beat(insert_beat(16'sh7fff, -16'sh8000));
        send_beat(insert_beat(16'sh5555, -16'sh5556));
        send_beat(insert_beat(-16'sh5556, 16'sh5555));
        send_beat(dump_beat());

        // Random part: the store fills early and then stays full, so later
        // inserts exercise the refusal path while dumps keep reading it back.
        while (beats_sent < ITEMS) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst; k++) begin
                if ($urandom_range(0, 99) < 22) begin
                    send_beat(dump_beat());
                end else begin
                    send_beat(insert_beat(pick_key(), pick_key()));
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                hold_until_drained();
            end else if ($urandom_range(0, 2) != 0) begin
                idle_for($urandom_range(1, 9));
            end
        end

        // Drain: wait for the outstanding results, then allow a full walk
        // for any stray beat to show itself.
        hold_until_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/tsiq_pkg.sv
sv/tsiq_ram.sv
sv/tsiq_cmp.sv
sv/two_key_sorted_insert_queue.sv
verif/tsiq_order_checker.sv
verif/tb_two_key_sorted_insert_queue.sv
